>>> hw/rtl/jpf_pkg.sv
// shared constants, types and state codes of the jaffe potential and force block
// no dependencies
package jpf_pkg;

    localparam int MAX_DIMS  = 3;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int R2_W      = 2 * DATA_W;
    localparam int S_W       = DATA_W + 1;
    localparam int LOG_FRAC  = 28;
    localparam int L_W       = 6 + LOG_FRAC;
    localparam int DEN_W     = R2_W + S_W;
    localparam int NUM_W     = 2 * DATA_W + 2 * FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int Q_DEPTH   = 4;
    localparam int QP_W      = $clog2(Q_DEPTH);
    localparam int QC_W      = $clog2(Q_DEPTH + 1);

    // ln(2) in q.28
    localparam logic [27:0] LN2_Q28 = 28'd186065280;

    // register indexes
    localparam logic [1:0] REG_DIMS  = 2'd0;
    localparam logic [1:0] REG_MASS  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;
    localparam logic [1:0] REG_PSCL  = 2'd3;

    // one classified word waiting for the back end
    typedef struct packed {
        logic [2:0]              neg;
        logic [2:0][DATA_W-1:0]  mag;
        logic [R2_W-1:0]         r2;
        logic [1:0]              dims;
    } job_t;

    // queue status seen by both sides
    typedef struct packed {
        logic            empty;
        logic [QC_W-1:0] count;
    } q_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_NORM_S,
        ST_LOG_S,
        ST_NORM_R,
        ST_LOG_R,
        ST_LN,
        ST_POT,
        ST_DEN_LO,
        ST_DEN_HI,
        ST_COMP,
        ST_DIV,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/jpf_front.sv
// front end: takes position words, forms magnitudes, signs and the squared radius
// depends on jpf_pkg
module jpf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        pos_x,
    input  logic [31:0]        pos_y,
    input  logic [31:0]        pos_z,
    input  logic [1:0]         dims_in_use,
    input  jpf_pkg::q_status_t qs,
    output logic               busy,
    output logic               push,
    output jpf_pkg::job_t      job_out
);
    import jpf_pkg::*;

    logic                   accept;
    logic [1:0]             dims_eff;
    logic [2:0][DATA_W-1:0] pos_in;
    logic [2:0][DATA_W-1:0] mag_in;
    logic [2:0]             neg_in;

    logic                   va_reg;
    logic [2:0][DATA_W-1:0] mag_a_reg;
    logic [2:0]             neg_a_reg;
    logic [1:0]             dims_a_reg;

    logic                   vb_reg;
    logic [2:0][DATA_W-1:0] mag_b_reg;
    logic [2:0]             neg_b_reg;
    logic [1:0]             dims_b_reg;
    logic [2:0][R2_W-1:0]   sq_b_reg;

    // credit check: queue plus words in flight must fit
    assign busy   = (QC_W'(qs.count) + QC_W'(va_reg) + QC_W'(vb_reg)) >= QC_W'(Q_DEPTH);
    assign accept = start & ~busy;

    // dimension count clamped to the legal range
    always_comb
    begin
        if (dims_in_use == 2'd0)
            dims_eff = 2'd1;
        else if (dims_in_use > 2'(MAX_DIMS))
            dims_eff = 2'(MAX_DIMS);
        else
            dims_eff = dims_in_use;
    end

    // sign and magnitude of each coordinate
    always_comb
    begin
        pos_in[0] = pos_x;
        pos_in[1] = pos_y;
        pos_in[2] = pos_z;
        for (int i = 0; i < 3; i++)
        begin
            neg_in[i] = pos_in[i][DATA_W-1];
            mag_in[i] = neg_in[i] ? (DATA_W'(0) - pos_in[i]) : pos_in[i];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= accept;
            vb_reg <= va_reg;
        end
    end

    // stage a: magnitudes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_a_reg  <= mag_in;
            neg_a_reg  <= neg_in;
            dims_a_reg <= dims_eff;
        end
    end

    // stage b: squares of the coordinates in use
    always_ff @(posedge clk)
    begin
        if (va_reg)
        begin
            mag_b_reg  <= mag_a_reg;
            neg_b_reg  <= neg_a_reg;
            dims_b_reg <= dims_a_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < dims_a_reg)
                    sq_b_reg[i] <= R2_W'(mag_a_reg[i]) * R2_W'(mag_a_reg[i]);
                else
                    sq_b_reg[i] <= '0;
            end
        end
    end

    // word into the queue
    assign push         = vb_reg;
    assign job_out.neg  = neg_b_reg;
    assign job_out.mag  = mag_b_reg;
    assign job_out.dims = dims_b_reg;
    assign job_out.r2   = sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];

endmodule

>>> hw/rtl/jpf_fifo.sv
// short queue between front and back end
// depends on jpf_pkg
module jpf_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jpf_pkg::job_t      wr_job,
    input  logic               pop,
    output jpf_pkg::job_t      rd_job,
    output jpf_pkg::q_status_t qs
);
    import jpf_pkg::*;

    job_t            slot_reg [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0] count_reg;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QP_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            count_reg <= count_reg + QC_W'(push) - QC_W'(pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    assign rd_job   = slot_reg[rd_ptr_reg];
    assign qs.count = count_reg;
    assign qs.empty = (count_reg == '0);

endmodule

>>> hw/rtl/jpf_back.sv
// back end sequencer: square root, two log2 runs, potential, radial divisions
// depends on jpf_pkg
module jpf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  jpf_pkg::q_status_t qs,
    input  jpf_pkg::job_t      job,
    output logic               pop,
    input  logic [31:0]        total_mass,
    input  logic [31:0]        scale_length,
    input  logic [31:0]        potential_scale,
    output logic [31:0]        potential,
    output logic [31:0]        acc_x,
    output logic [31:0]        acc_y,
    output logic [31:0]        acc_z,
    output logic               saturated,
    output logic               done
);
    import jpf_pkg::*;

    state_t                 state_reg, state_next;
    job_t                   job_reg, job_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [34:0]            rem_reg, rem_next;
    logic [31:0]            root_reg, root_next;
    logic [R2_W-1:0]        rad_reg, rad_next;
    logic [S_W-1:0]         xn_reg, xn_next;
    logic [5:0]             n_reg, n_next;
    logic [31:0]            m_reg, m_next;
    logic [LOG_FRAC-1:0]    frac_reg, frac_next;
    logic [L_W-1:0]         ls_reg, ls_next;
    logic [L_W-1:0]         d_reg, d_next;
    logic [L_W-1:0]         ln_reg, ln_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [DEN_W-1:0]       drem_reg, drem_next;
    logic [NUM_W-1:0]       quo_reg, quo_next;
    logic [1:0]             ci_reg, ci_next;
    logic [31:0]            pot_reg, pot_next;
    logic [2:0][31:0]       acc_reg, acc_next;
    logic                   sat_reg, sat_next;
    logic                   done_reg, done_next;
    // s = r + a kept for the denominator
    logic [S_W-1:0]         s_hold_reg, s_hold_next;

    logic [31:0]            a_eff;
    logic [34:0]            rem2;
    logic [34:0]            trial;
    logic [31:0]            root_step;
    logic [63:0]            sq;
    logic [32:0]            t;
    logic [LOG_FRAC-1:0]    frac_step;
    logic [L_W-1:0]         l_val;
    logic [62:0]            ln_prod;
    logic [66:0]            pot_prod;
    logic [38:0]            pmag;
    logic [R2_W:0]          den_part_lo;
    logic [R2_W:0]          den_part_hi;
    logic [31:0]            mag_sel;
    logic                   neg_sel;
    logic [63:0]            num_prod;
    logic [DEN_W:0]         rp;
    logic                   dge;
    logic [NUM_W-1:0]       limit;
    logic [31:0]            v;

    // datapath helpers
    always_comb
    begin
        a_eff     = (scale_length == 32'd0) ? 32'd1 : scale_length;
        rem2      = {rem_reg[32:0], rad_reg[R2_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        root_step = {root_reg[30:0], (rem2 >= trial)};
        sq        = 64'(m_reg) * 64'(m_reg);
        t         = sq[63:31];
        frac_step = {frac_reg[LOG_FRAC-2:0], t[32]};
        l_val     = {n_reg, frac_step};
        ln_prod   = 63'(d_reg) * 63'(LN2_Q28) + 63'(1 << 27);
        pot_prod  = 67'(potential_scale) * 67'(ln_reg) + 67'(1 << 27);
        pmag      = pot_prod[66:28];
        // r2 split in halves, each times s
        den_part_lo = 65'(job_reg.r2[31:0]) * 65'(s_hold_reg);
        den_part_hi = 65'(job_reg.r2[63:32]) * 65'(s_hold_reg);
        if (ci_reg == 2'd0)
        begin
            mag_sel = job_reg.mag[0];
            neg_sel = job_reg.neg[0];
        end
        else if (ci_reg == 2'd1)
        begin
            mag_sel = job_reg.mag[1];
            neg_sel = job_reg.neg[1];
        end
        else
        begin
            mag_sel = job_reg.mag[2];
            neg_sel = job_reg.neg[2];
        end
        num_prod = 64'(mag_sel) * 64'(total_mass);
        rp       = {drem_reg, num_reg[NUM_W-1]};
        dge      = rp >= {1'b0, den_reg};
        limit    = neg_sel ? NUM_W'(32'h7FFF_FFFF) : NUM_W'(32'h8000_0000);
        v        = (quo_reg > limit) ? limit[31:0] : quo_reg[31:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        rad_reg    <= rad_next;
        xn_reg     <= xn_next;
        n_reg      <= n_next;
        m_reg      <= m_next;
        frac_reg   <= frac_next;
        ls_reg     <= ls_next;
        d_reg      <= d_next;
        ln_reg     <= ln_next;
        den_reg    <= den_next;
        num_reg    <= num_next;
        drem_reg   <= drem_next;
        quo_reg    <= quo_next;
        ci_reg     <= ci_next;
        pot_reg    <= pot_next;
        acc_reg    <= acc_next;
        sat_reg    <= sat_next;
        s_hold_reg <= s_hold_next;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        rad_next    = rad_reg;
        xn_next     = xn_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        frac_next   = frac_reg;
        ls_next     = ls_reg;
        d_next      = d_reg;
        ln_next     = ln_reg;
        den_next    = den_reg;
        num_next    = num_reg;
        drem_next   = drem_reg;
        quo_next    = quo_reg;
        ci_next     = ci_reg;
        pot_next    = pot_reg;
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        s_hold_next = s_hold_reg;
        done_next   = 1'b0;
        pop         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qs.empty)
                begin
                    pop      = 1'b1;
                    job_next = job;
                    acc_next = '0;
                    pot_next = '0;
                    sat_next = 1'b0;
                    rem_next = '0;
                    root_next = '0;
                    rad_next = job.r2;
                    cnt_next = CNT_W'(31);
                    if (job.r2 == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SQRT;
                end
            end
            // one root bit a cycle
            ST_SQRT:
            begin
                rem_next  = (rem2 >= trial) ? (rem2 - trial) : rem2;
                root_next = root_step;
                rad_next  = {rad_reg[R2_W-3:0], 2'b00};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    s_hold_next = S_W'(root_step) + S_W'(a_eff);
                    xn_next     = S_W'(root_step) + S_W'(a_eff);
                    n_next      = 6'd32;
                    state_next  = ST_NORM_S;
                end
            end
            // leading one search, one bit a cycle
            ST_NORM_S, ST_NORM_R:
            begin
                if (xn_reg[S_W-1])
                begin
                    m_next    = xn_reg[S_W-1:1];
                    frac_next = '0;
                    cnt_next  = CNT_W'(LOG_FRAC - 1);
                    state_next = (state_reg == ST_NORM_S) ? ST_LOG_S : ST_LOG_R;
                end
                else
                begin
                    xn_next = {xn_reg[S_W-2:0], 1'b0};
                    n_next  = n_reg - 6'd1;
                end
            end
            // one fraction bit per squaring
            ST_LOG_S, ST_LOG_R:
            begin
                m_next    = t[32] ? t[32:1] : t[31:0];
                frac_next = frac_step;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (state_reg == ST_LOG_S)
                    begin
                        ls_next    = l_val;
                        xn_next    = {1'b0, root_reg};
                        n_next     = 6'd32;
                        state_next = ST_NORM_R;
                    end
                    else
                    begin
                        d_next     = (ls_reg >= l_val) ? (ls_reg - l_val) : '0;
                        state_next = ST_LN;
                    end
                end
            end
            ST_LN:
            begin
                ln_next    = ln_prod[61:28];
                state_next = ST_POT;
            end
            // potential with clipping
            ST_POT:
            begin
                if (pmag > 39'(33'h1_0000_0000 >> 1))
                begin
                    pot_next = 32'h8000_0000;
                    sat_next = 1'b1;
                end
                else
                    pot_next = 32'd0 - pmag[31:0];
                state_next = ST_DEN_LO;
            end
            ST_DEN_LO:
            begin
                den_next   = DEN_W'(den_part_lo);
                state_next = ST_DEN_HI;
            end
            ST_DEN_HI:
            begin
                den_next   = den_reg + (DEN_W'(den_part_hi) << 32);
                ci_next    = 2'd0;
                state_next = ST_COMP;
            end
            // next component or finish
            ST_COMP:
            begin
                if (ci_reg >= job_reg.dims)
                    state_next = ST_DONE;
                else if (mag_sel == 32'd0)
                    ci_next = ci_reg + 2'd1;
                else
                begin
                    num_next   = {num_prod, (2 * FRAC_BITS)'(0)};
                    drem_next  = '0;
                    quo_next   = '0;
                    cnt_next   = CNT_W'(NUM_W - 1);
                    state_next = ST_DIV;
                end
            end
            // restoring division, one quotient bit a cycle
            ST_DIV:
            begin
                drem_next = dge ? DEN_W'(rp - {1'b0, den_reg}) : rp[DEN_W-1:0];
                quo_next  = {quo_reg[NUM_W-2:0], dge};
                num_next  = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (quo_reg > limit)
                    sat_next = 1'b1;
                if (ci_reg == 2'd0)
                    acc_next[0] = neg_sel ? v : (32'd0 - v);
                else if (ci_reg == 2'd1)
                    acc_next[1] = neg_sel ? v : (32'd0 - v);
                else
                    acc_next[2] = neg_sel ? v : (32'd0 - v);
                ci_next    = ci_reg + 2'd1;
                state_next = ST_COMP;
            end
            ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign potential = pot_reg;
    assign acc_x     = acc_reg[0];
    assign acc_y     = acc_reg[1];
    assign acc_z     = acc_reg[2];
    assign saturated = sat_reg;
    assign done      = done_reg;

endmodule

>>> hw/rtl/jaffe_potential_force_top.sv
// jaffe potential and force: an accepted word passes front stages a and b into the queue,
// then the back end runs the root, two leading-one searches and log runs, ln, potential and
// denominator, and a division per used component (skipped when its coordinate is zero).
// throughput is one word per back-end run, set by the single shared sequencer with its
// bit-serial root, log and divide steps; a 4-word queue lets new words enter meanwhile.
// results come on done for one cycle and cannot be stalled; rst_n clears control state.
module jaffe_potential_force_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    output logic        done,
    output logic [31:0] potential,
    output logic [31:0] acc_x,
    output logic [31:0] acc_y,
    output logic [31:0] acc_z,
    output logic        saturated
);
    import jpf_pkg::*;

    logic [1:0]  dims_reg;
    logic [31:0] mass_reg;
    logic [31:0] scale_reg;
    logic [31:0] pscl_reg;
    logic        wr_en;

    logic        push;
    logic        pop;
    job_t        wr_job;
    job_t        rd_job;
    q_status_t   qs;

    // register writes
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg  <= 2'd3;
            mass_reg  <= 32'h0001_0000;
            scale_reg <= 32'h0001_0000;
            pscl_reg  <= 32'h0001_0000;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DIMS:  dims_reg  <= pwdata[1:0];
                REG_MASS:  mass_reg  <= pwdata;
                REG_SCALE: scale_reg <= pwdata;
                REG_PSCL:  pscl_reg  <= pwdata;
                default:   dims_reg  <= dims_reg;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[3:2])
            REG_DIMS:  prdata = {30'd0, dims_reg};
            REG_MASS:  prdata = mass_reg;
            REG_SCALE: prdata = scale_reg;
            REG_PSCL:  prdata = pscl_reg;
            default:   prdata = 32'd0;
        endcase
    end

    jpf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .dims_in_use (dims_reg),
        .qs          (qs),
        .busy        (busy),
        .push        (push),
        .job_out     (wr_job)
    );

    jpf_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .qs     (qs)
    );

    jpf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .qs              (qs),
        .job             (rd_job),
        .pop             (pop),
        .total_mass      (mass_reg),
        .scale_length    (scale_reg),
        .potential_scale (pscl_reg),
        .potential       (potential),
        .acc_x           (acc_x),
        .acc_y           (acc_y),
        .acc_z           (acc_z),
        .saturated       (saturated),
        .done            (done)
    );

endmodule

>>> hw/rtl/jpf_checker.sv
// port-level checks of the jaffe potential and force block, bound to the top level
// no dependencies
module jpf_prop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] potential
);

    // done is a one-cycle strobe
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for two cycles");

    // the potential is never positive
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (potential[31] || (potential == 32'd0)))
        else $error("positive potential");

    // the queue only fills through an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted word");

endmodule

bind jaffe_potential_force_top jpf_prop_checker u_jpf_prop_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .potential (potential)
);
